// ===== hdl/cdf_pkg.sv =====
// Shared types and constants for the coordinate duplicate finder.
// No dependencies; imported by every module of the block except cdf_ram.
package cdf_pkg;

    localparam int MAX_GROUPS_DEF    = 256;
    localparam int MAX_DIMS_DEF      = 4;
    localparam int POSITION_BITS_DEF = 16;

    localparam int COORD_W         = 32;
    localparam int NUM_COORD_PORTS = 4;
    localparam int DIMS_W          = 3;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd2;
    localparam int GROUP_INDEX_W   = 8;
    localparam int FIRST_POS_W     = 16;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } cdf_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;  // latch the point, restart the scan
        logic read;  // issue a table read at the scan pointer
        logic hit;   // last compared entry matched
        logic miss;  // table exhausted without a match
    } cdf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic match;       // compare result valid and equal
        logic ptr_at_end;  // scan pointer reached the group count
    } cdf_status_t;

endpackage

// ===== hdl/cdf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cdf_ctrl.sv =====
// Controller state machine for the duplicate finder: sequences the table scan.
// Depends on cdf_pkg.
module cdf_ctrl import cdf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cdf_status_t status,
    output cdf_cmd_t    cmd,
    output logic        busy
);

    cdf_state_t state_reg;
    cdf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // match on the entry read last cycle wins over further reads
                if (status.match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!status.ptr_at_end)
                begin
                    cmd.read = 1'b1;
                end
                else
                begin
                    cmd.miss   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== hdl/cdf_datapath.sv =====
// Datapath of the duplicate finder: point latch, table RAMs, compare,
// group and position counters, result registers. Depends on cdf_pkg, cdf_ram.
module cdf_datapath import cdf_pkg::*; #(
    parameter int MAX_GROUPS    = MAX_GROUPS_DEF,
    parameter int MAX_DIMS      = MAX_DIMS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cdf_cmd_t                 cmd,
    output cdf_status_t              status,
    input  logic                     cfg_we,
    input  logic [DIMS_W-1:0]        cfg_wdata,
    input  logic [COORD_W-1:0]       coord_in [NUM_COORD_PORTS],
    input  logic                     last_in,
    output logic                     result_valid,
    output logic [GROUP_INDEX_W-1:0] group_index,
    output logic [FIRST_POS_W-1:0]   first_position,
    output logic                     is_new,
    output logic                     table_full
);

    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CW = $clog2(MAX_GROUPS + 1);
    localparam int RW = MAX_DIMS * COORD_W;
    localparam logic [CW-1:0]            COUNT_FULL = CW'(MAX_GROUPS);
    localparam logic [POSITION_BITS-1:0] POS_MAX    = '1;

    logic [DIMS_W-1:0]        dims_reg;
    logic [DIMS_W-1:0]        act_dims;
    logic [COORD_W-1:0]       point_reg [MAX_DIMS];
    logic                     last_reg;
    logic [CW-1:0]            ptr_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic                     cmp_valid_reg;
    logic [GW-1:0]            cmp_idx_reg;

    logic [RW-1:0]            row_wdata;
    logic [RW-1:0]            row_rdata;
    logic [POSITION_BITS-1:0] pos_rdata;
    logic                     row_eq;
    logic                     tbl_full;
    logic                     insert;
    logic                     finish;

    logic [GW-1:0]            grp_sel;
    logic [POSITION_BITS-1:0] pos_sel;
    logic [GW+GROUP_INDEX_W-1:0]          grp_wide;
    logic [POSITION_BITS+FIRST_POS_W-1:0] pos_wide;

    logic                     valid_reg;
    logic [GROUP_INDEX_W-1:0] group_reg;
    logic [FIRST_POS_W-1:0]   first_reg;
    logic                     new_reg;
    logic                     full_reg;
    logic                     new_next;
    logic                     full_next;

    // config register; out-of-range counts are clamped at use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= DIMS_RESET;
        end
        else if (cfg_we)
        begin
            dims_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (dims_reg == '0)
        begin
            act_dims = DIMS_W'(1);
        end
        else if (dims_reg > DIMS_W'(MAX_DIMS))
        begin
            act_dims = DIMS_W'(MAX_DIMS);
        end
        else
        begin
            act_dims = dims_reg;
        end
    end

    // point latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                point_reg[k] <= coord_in[k];
            end
            last_reg <= last_in;
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            row_wdata[k*COORD_W +: COORD_W] = point_reg[k];
        end
    end

    always_comb
    begin
        row_eq = 1'b1;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            if ((DIMS_W'(k) < act_dims) && (row_rdata[k*COORD_W +: COORD_W] != point_reg[k]))
            begin
                row_eq = 1'b0;
            end
        end
    end

    assign tbl_full = (count_reg == COUNT_FULL);
    assign insert   = cmd.miss && !tbl_full;
    assign finish   = cmd.hit || cmd.miss;

    assign status.match      = cmp_valid_reg && row_eq;
    assign status.ptr_at_end = (ptr_reg == count_reg);

    // scan pointer and compare tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.read;
            if (cmd.load)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.read)
            begin
                ptr_reg <= ptr_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            cmp_idx_reg <= ptr_reg[GW-1:0];
        end
    end

    // group count and set position
    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        if (finish)
        begin
            if (last_reg)
            begin
                count_next = '0;
                pos_next   = '0;
            end
            else
            begin
                if (insert)
                begin
                    count_next = count_reg + CW'(1);
                end
                if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_reg + POSITION_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

    cdf_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_GROUPS)
    ) u_coord_ram (
        .clk   (clk),
        .we    (insert),
        .waddr (count_reg[GW-1:0]),
        .wdata (row_wdata),
        .re    (cmd.read),
        .raddr (ptr_reg[GW-1:0]),
        .rdata (row_rdata)
    );

    cdf_ram #(
        .WIDTH (POSITION_BITS),
        .DEPTH (MAX_GROUPS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (insert),
        .waddr (count_reg[GW-1:0]),
        .wdata (pos_reg),
        .re    (cmd.read),
        .raddr (ptr_reg[GW-1:0]),
        .rdata (pos_rdata)
    );

    // result select
    always_comb
    begin
        grp_sel   = '0;
        pos_sel   = pos_reg;
        new_next  = 1'b0;
        full_next = 1'b0;
        if (cmd.hit)
        begin
            grp_sel = cmp_idx_reg;
            pos_sel = pos_rdata;
        end
        else if (insert)
        begin
            grp_sel  = count_reg[GW-1:0];
            new_next = 1'b1;
        end
        else
        begin
            full_next = 1'b1;
        end
    end

    assign grp_wide = {{GROUP_INDEX_W{1'b0}}, grp_sel};
    assign pos_wide = {{FIRST_POS_W{1'b0}}, pos_sel};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            group_reg <= grp_wide[GROUP_INDEX_W-1:0];
            first_reg <= pos_wide[FIRST_POS_W-1:0];
            new_reg   <= new_next;
            full_reg  <= full_next;
        end
    end

    assign result_valid   = valid_reg;
    assign group_index    = group_reg;
    assign first_position = first_reg;
    assign is_new         = new_reg;
    assign table_full     = full_reg;

endmodule

// ===== hdl/coordinate_duplicate_finder_unit.sv =====
// Top level of the coordinate duplicate finder.
// Depends on cdf_pkg, cdf_ctrl, cdf_datapath (which uses cdf_ram).

// One transaction carries a point of up to four Q16.16 coordinates; the block
// answers with exactly one result, strobed on result_valid for a single cycle.
// The receiver cannot stall, so results must be taken when strobed. A start is
// taken when busy is low. The point is compared, raw bits, on its first
// dims_in_use coordinates (0 acts as 1, above MAX_DIMS acts as MAX_DIMS)
// against the stored distinct points in insertion order. A hit returns the
// group index and the first position of that group; a miss appends a new
// group (is_new) or, with MAX_GROUPS groups stored, reports table_full with
// group_index 0 and the point's own position. A point with last_in_set clears
// the table and the position counter after its own result. The position
// counter saturates at 2^POSITION_BITS - 1. From start to strobe, the block
// latches the point, reads one table row per cycle in insertion order, and
// ends on a hit or, after the last stored group, with a final compare/insert.
// busy drops in the strobe cycle, and start may be asserted there.
// cfg_we/cfg_wdata write dims_in_use (reset 2); write it only while idle.
// No clearing pass is needed after reset: table entries are only read below
// the group count.
module coordinate_duplicate_finder_unit import cdf_pkg::*; #(
    parameter int MAX_GROUPS    = MAX_GROUPS_DEF,
    parameter int MAX_DIMS      = MAX_DIMS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // command channel
    input  logic                     start,
    output logic                     busy,
    input  logic signed [COORD_W-1:0] coord_0,
    input  logic signed [COORD_W-1:0] coord_1,
    input  logic signed [COORD_W-1:0] coord_2,
    input  logic signed [COORD_W-1:0] coord_3,
    input  logic                     last_in_set,
    // configuration
    input  logic                     cfg_we,
    input  logic [DIMS_W-1:0]        cfg_wdata,
    // result channel
    output logic                     result_valid,
    output logic [GROUP_INDEX_W-1:0] group_index,
    output logic [FIRST_POS_W-1:0]   first_position,
    output logic                     is_new,
    output logic                     table_full
);

    cdf_cmd_t           cmd;
    cdf_status_t        status;
    logic               ctrl_busy;
    logic [COORD_W-1:0] coord_in [NUM_COORD_PORTS];

    assign coord_in[0] = coord_0;
    assign coord_in[1] = coord_1;
    assign coord_in[2] = coord_2;
    assign coord_in[3] = coord_3;

    // Controller: IDLE -> SCAN on start; SCAN reads one table row per cycle
    // and finishes on a hit or when the pointer reaches the group count.
    cdf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (ctrl_busy)
    );

    // Datapath: table RAMs, compare against the registered read row,
    // counters and result registers.
    cdf_datapath #(
        .MAX_GROUPS    (MAX_GROUPS),
        .MAX_DIMS      (MAX_DIMS),
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .coord_in       (coord_in),
        .last_in        (last_in_set),
        .result_valid   (result_valid),
        .group_index    (group_index),
        .first_position (first_position),
        .is_new         (is_new),
        .table_full     (table_full)
    );

    assign busy = ctrl_busy;

endmodule

// ===== hdl/cdf_checker.sv =====
// Port-level assertions for the coordinate duplicate finder, bound to the top.
// Depends on cdf_pkg and coordinate_duplicate_finder_unit.
module cdf_checker import cdf_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     result_valid,
    input logic [GROUP_INDEX_W-1:0] group_index,
    input logic                     is_new,
    input logic                     table_full
);

    // an accepted transaction keeps the block busy until its result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("busy not raised after accepted start");

    // the scan ends exactly when the result is strobed
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
    else $error("busy dropped without a result");

    // strobe lasts one cycle; the next result needs a new transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(is_new && table_full))
    else $error("result both new and table full");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && table_full) |-> (group_index == '0))
    else $error("table full result with nonzero group index");

endmodule

bind coordinate_duplicate_finder_unit cdf_checker u_cdf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .group_index  (group_index),
    .is_new       (is_new),
    .table_full   (table_full)
);
